/* hw/rtl/framebuffer_rect_fill_sprite_blit_macros.svh */
// assertion macros used by the blitter top level
`ifndef FRAMEBUFFER_RECT_FILL_SPRITE_BLIT_MACROS_SVH
`define FRAMEBUFFER_RECT_FILL_SPRITE_BLIT_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define FRSB_ASSERT_IMPL(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("blitter check failed");

// next-cycle implication, sampled on clk, off during reset
`define FRSB_ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("blitter check failed");

`endif

/* hw/rtl/fbrsb_pkg.sv */
// shared constants, types and codes of the blitter
`timescale 1ns / 1ps
`default_nettype none

package fbrsb_pkg;

	localparam int SCREEN_WIDTH  = 640;
	localparam int SCREEN_HEIGHT = 480;
	localparam int SPRITE_SIZE   = 16;
	localparam int SPRITE_COUNT  = 256;

	localparam int SPRITE_BYTES = SPRITE_SIZE * SPRITE_SIZE;
	localparam int FB_BYTES     = SCREEN_WIDTH * SCREEN_HEIGHT;
	localparam int STORE_BYTES  = SPRITE_COUNT * SPRITE_BYTES;
	localparam int CLR_LEN      = (FB_BYTES > STORE_BYTES) ? FB_BYTES : STORE_BYTES;

	localparam int FA = $clog2(FB_BYTES);
	localparam int SA = $clog2(STORE_BYTES);
	localparam int CW = $clog2(CLR_LEN);
	localparam int YW = $clog2(SCREEN_HEIGHT);
	localparam int KW = $clog2(SPRITE_BYTES);

	typedef enum logic [1:0] {
		KIND_FILL = 2'd0,
		KIND_LOAD = 2'd1,
		KIND_DRAW = 2'd2,
		KIND_READ = 2'd3
	} cmd_kind_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SETUP,
		ST_RUN,
		ST_DRAIN,
		ST_RD,
		ST_RD_OUT
	} eng_state_t;

	typedef struct packed {
		cmd_kind_t   kind;
		logic [15:0] x;
		logic [15:0] y;
		logic [15:0] width;
		logic [15:0] height;
		logic [7:0]  color;
		logic [7:0]  sprite_id;
		logic [7:0]  sprite_offset;
	} cmd_t;

	typedef struct packed {
		logic ready;
		logic res_valid;
	} eng_stat_t;

endpackage

`default_nettype wire

/* hw/rtl/framebuffer_rect_fill_sprite_blit.sv */
// framebuffer_rect_fill_sprite_blit: 2d drawing engine top level
// input channel (in_valid / in_stall) takes one command request per kind:
//   fill rectangle, load sprite byte, draw 16x16 sprite, read pixel.
// output channel (out_valid / out_stall) returns one pixel per read request.
// steps per request, from acceptance to the earliest next acceptance:
//   load sprite byte, rejected fill or bad sprite id: setup, then idle
//   fill: setup, run, drain; one pixel per cycle via the frame buffer port
//   draw: setup, run, drain; one sprite byte read, one pixel write per cycle
//   read: setup, read, wait for room in the output register, then idle
// the frame buffer has a single write port, shared by the clearing pass
// and the pixel writes of fill and draw.
// after reset the block runs a clearing pass, zeroing the frame buffer and
// writing each sprite with its own number; in_stall stays high meanwhile.
// a finished pixel waits in an output register; while the receiver stalls,
// new requests are still taken, and only a second read waits for room.
`timescale 1ns / 1ps
`default_nettype none
`include "framebuffer_rect_fill_sprite_blit_macros.svh"

module framebuffer_rect_fill_sprite_blit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  kind,
	input  wire logic [15:0] x,
	input  wire logic [15:0] y,
	input  wire logic [15:0] width,
	input  wire logic [15:0] height,
	input  wire logic [7:0]  color,
	input  wire logic [7:0]  sprite_id,
	input  wire logic [7:0]  sprite_offset,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic      [7:0]  pixel
);

	import fbrsb_pkg::*;

	cmd_t      cmd;
	eng_stat_t eng_stat;
	logic [7:0] res_pixel;
	logic       res_room, res_take, out_take;
	logic       ovalid_q;
	logic [7:0] pixel_q;

	assign cmd.kind          = cmd_kind_t'(kind);
	assign cmd.x             = x;
	assign cmd.y             = y;
	assign cmd.width         = width;
	assign cmd.height        = height;
	assign cmd.color         = color;
	assign cmd.sprite_id     = sprite_id;
	assign cmd.sprite_offset = sprite_offset;

	assign out_take = ovalid_q && !out_stall;
	assign res_room = !ovalid_q || !out_stall;
	assign res_take = eng_stat.res_valid && res_room;

	fbrsb_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.cmd_valid (in_valid),
		.res_room  (res_room),
		.stat      (eng_stat),
		.res_pixel (res_pixel)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (res_take) begin
			ovalid_q <= 1'b1;
		end else if (out_take) begin
			ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			pixel_q <= res_pixel;
		end
	end

	assign in_stall  = !eng_stat.ready;
	assign out_valid = ovalid_q;
	assign pixel     = pixel_q;

	// a taken request keeps the engine busy at least through its setup state
	`FRSB_ASSERT_NEXT(a_busy_after_take, in_valid && !in_stall, in_stall)
	// no request is taken while a read result is pending in the engine
	`FRSB_ASSERT_IMPL(a_stall_during_result, eng_stat.res_valid, in_stall)
	// the output register only fills from an engine result
	`FRSB_ASSERT_IMPL(a_out_from_engine, $rose(out_valid), $past(eng_stat.res_valid))

endmodule

`default_nettype wire

/* hw/rtl/fbrsb_ram.sv */
// generic one-write one-read memory with registered read data
`timescale 1ns / 1ps
`default_nettype none

module fbrsb_ram #(
	parameter int DEPTH = 256,
	parameter int WIDTH = 8,
	parameter int AW    = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

/* hw/rtl/fbrsb_engine.sv */
// command sequencer with the frame buffer and sprite store
`timescale 1ns / 1ps
`default_nettype none

module fbrsb_engine (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire fbrsb_pkg::cmd_t      cmd,
	input  wire logic                 cmd_valid,
	input  wire logic                 res_room,
	output fbrsb_pkg::eng_stat_t      stat,
	output logic               [7:0]  res_pixel
);

	import fbrsb_pkg::*;

	eng_state_t state_q, state_d;
	cmd_t       cmd_q;

	logic [CW-1:0] clr_cnt_q;

	logic [16:0]   cur_x_q, cur_y_q, x_end_q, y_end_q;
	logic [FA-1:0] row_base_q;
	logic [KW-1:0] k_q;
	logic          is_draw_q;
	logic          in_range_q;
	logic          we_s1;
	logic [FA-1:0] addr_s1;

	// setup arithmetic
	logic [15:0]   x1;
	logic [16:0]   yh;
	logic          fill_ok, fill_empty, id_ok, pix_in_range, is_draw;
	logic [FA-1:0] y_base;

	// stepping
	logic          col_last, row_last, run_we;
	logic [FA-1:0] run_addr;

	// memory ports
	logic          fb_we, fb_re, spr_we, spr_re;
	logic [FA-1:0] fb_waddr, fb_raddr;
	logic [SA-1:0] spr_waddr, spr_raddr;
	logic [7:0]    fb_wdata, fb_rdata, spr_wdata, spr_rdata;

	logic clearing, cmd_take;

	assign x1      = cmd_q.x + cmd_q.width;
	assign yh      = {1'b0, cmd_q.y} + {1'b0, cmd_q.height};
	assign fill_ok = ({1'b0, cmd_q.x} < 17'(SCREEN_WIDTH)) &&
		({1'b0, cmd_q.y} < 17'(SCREEN_HEIGHT)) &&
		({1'b0, x1} <= 17'(SCREEN_WIDTH)) && (yh <= 17'(SCREEN_HEIGHT));
	assign fill_empty   = (x1 <= cmd_q.x) || (cmd_q.height == 16'd0);
	assign id_ok        = {1'b0, cmd_q.sprite_id} < 9'(SPRITE_COUNT);
	assign pix_in_range = ({1'b0, cmd_q.x} < 17'(SCREEN_WIDTH)) &&
		({1'b0, cmd_q.y} < 17'(SCREEN_HEIGHT));
	assign is_draw      = (cmd_q.kind == KIND_DRAW);
	// only meaningful when y is on screen
	assign y_base       = FA'(cmd_q.y[YW-1:0]) * FA'(SCREEN_WIDTH);

	assign col_last = (cur_x_q + 17'd1) == x_end_q;
	assign row_last = (cur_y_q + 17'd1) == y_end_q;
	assign run_we   = (cur_x_q < 17'(SCREEN_WIDTH)) && (cur_y_q < 17'(SCREEN_HEIGHT));
	assign run_addr = row_base_q + FA'(cur_x_q);

	assign clearing = (state_q == ST_CLEAR);
	assign cmd_take = (state_q == ST_IDLE) && cmd_valid;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (clr_cnt_q == CW'(CLR_LEN - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (cmd_valid) begin
					state_d = ST_SETUP;
				end
			end
			ST_SETUP: begin
				case (cmd_q.kind)
					KIND_FILL: state_d = (fill_ok && !fill_empty) ? ST_RUN : ST_IDLE;
					KIND_LOAD: state_d = ST_IDLE;
					KIND_DRAW: state_d = id_ok ? ST_RUN : ST_IDLE;
					KIND_READ: state_d = ST_RD;
					default:   state_d = ST_IDLE;
				endcase
			end
			ST_RUN: begin
				if (col_last && row_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: state_d = ST_IDLE;
			ST_RD:    state_d = ST_RD_OUT;
			ST_RD_OUT: begin
				if (res_room) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			clr_cnt_q <= '0;
			we_s1     <= 1'b0;
		end else begin
			state_q <= state_d;
			if (clearing) begin
				clr_cnt_q <= clr_cnt_q + CW'(1);
			end
			we_s1 <= (state_q == ST_RUN) && run_we;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_take) begin
			cmd_q <= cmd;
		end
		case (state_q)
			ST_SETUP: begin
				cur_x_q    <= {1'b0, cmd_q.x};
				cur_y_q    <= {1'b0, cmd_q.y};
				row_base_q <= y_base;
				k_q        <= '0;
				in_range_q <= pix_in_range;
				is_draw_q  <= is_draw;
				x_end_q    <= is_draw ? ({1'b0, cmd_q.x} + 17'(SPRITE_SIZE)) : {1'b0, x1};
				y_end_q    <= is_draw ? ({1'b0, cmd_q.y} + 17'(SPRITE_SIZE)) : yh;
			end
			ST_RUN: begin
				addr_s1 <= run_addr;
				k_q     <= k_q + KW'(1);
				if (col_last) begin
					cur_x_q    <= {1'b0, cmd_q.x};
					cur_y_q    <= cur_y_q + 17'd1;
					row_base_q <= row_base_q + FA'(SCREEN_WIDTH);
				end else begin
					cur_x_q <= cur_x_q + 17'd1;
				end
			end
			default: begin
			end
		endcase
	end

	// frame buffer: clear pass, then pixel writes one stage behind the sprite read
	assign fb_we    = clearing ? ({1'b0, clr_cnt_q} < (CW + 1)'(FB_BYTES)) : we_s1;
	assign fb_waddr = clearing ? FA'(clr_cnt_q) : addr_s1;
	assign fb_wdata = clearing ? 8'd0 : (is_draw_q ? spr_rdata : cmd_q.color);
	assign fb_re    = (state_q == ST_RD);
	assign fb_raddr = row_base_q + FA'(cmd_q.x);

	// sprite store: clear pass writes the sprite number into each byte
	assign spr_we    = clearing ? ({1'b0, clr_cnt_q} < (CW + 1)'(STORE_BYTES)) :
		((state_q == ST_SETUP) && (cmd_q.kind == KIND_LOAD) && id_ok);
	assign spr_waddr = clearing ? SA'(clr_cnt_q) : SA'({cmd_q.sprite_id, cmd_q.sprite_offset});
	assign spr_wdata = clearing ? clr_cnt_q[15:8] : cmd_q.color;
	assign spr_re    = (state_q == ST_RUN);
	assign spr_raddr = SA'({cmd_q.sprite_id, k_q});

	fbrsb_ram #(
		.DEPTH (FB_BYTES),
		.WIDTH (8),
		.AW    (FA)
	) u_fb (
		.clk   (clk),
		.we    (fb_we),
		.waddr (fb_waddr),
		.wdata (fb_wdata),
		.re    (fb_re),
		.raddr (fb_raddr),
		.rdata (fb_rdata)
	);

	fbrsb_ram #(
		.DEPTH (STORE_BYTES),
		.WIDTH (8),
		.AW    (SA)
	) u_spr (
		.clk   (clk),
		.we    (spr_we),
		.waddr (spr_waddr),
		.wdata (spr_wdata),
		.re    (spr_re),
		.raddr (spr_raddr),
		.rdata (spr_rdata)
	);

	assign stat.ready     = (state_q == ST_IDLE);
	assign stat.res_valid = (state_q == ST_RD_OUT);
	assign res_pixel      = in_range_q ? fb_rdata : 8'd0;

endmodule

`default_nettype wire

/* tb/tb_framebuffer_rect_fill_sprite_blit.sv */
// self-checking testbench for the framebuffer fill and sprite blit engine
`timescale 1ns / 1ps

module tb_framebuffer_rect_fill_sprite_blit;

	import fbrsb_pkg::*;

	localparam int unsigned SCENE_ITEMS  = 1525;
	localparam int unsigned DRAIN_CYCLES = 16;
	localparam logic [15:0] SW16 = 16'(SCREEN_WIDTH);
	localparam logic [15:0] SH16 = 16'(SCREEN_HEIGHT);

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [1:0]  kind = 2'd0;
	logic [15:0] x = 16'd0;
	logic [15:0] y = 16'd0;
	logic [15:0] width = 16'd0;
	logic [15:0] height = 16'd0;
	logic [7:0]  color = 8'd0;
	logic [7:0]  sprite_id = 8'd0;
	logic [7:0]  sprite_offset = 8'd0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [7:0]  pixel;

	logic [7:0]  fb_model [FB_BYTES];
	logic [7:0]  sprite_model [STORE_BYTES];
	logic [7:0]  pending_pixels [$];
	int unsigned fail_count = 0;
	bit          tx_gaps_on = 1'b1;
	bit          rx_stall_on = 1'b1;
	int unsigned rx_hold = 0;

	framebuffer_rect_fill_sprite_blit DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.kind(kind),
		.x(x),
		.y(y),
		.width(width),
		.height(height),
		.color(color),
		.sprite_id(sprite_id),
		.sprite_offset(sprite_offset),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.pixel(pixel)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	initial begin
		#40_000_000;
		$display("tb: failure");
		$finish;
	end

	// receiver back-pressure: mostly short bursts, now and then a long one
	always @(posedge clk) begin
		if (!rx_stall_on) begin
			out_stall <= 1'b0;
			rx_hold <= 0;
		end else if (rx_hold != 0) begin
			rx_hold <= rx_hold - 1;
		end else begin
			int unsigned roll;
			roll = $urandom_range(0, 99);
			if (roll < 70) begin
				out_stall <= 1'b0;
				rx_hold <= $urandom_range(0, 3);
			end else if (roll < 95) begin
				out_stall <= 1'b1;
				rx_hold <= $urandom_range(0, 4);
			end else begin
				out_stall <= 1'b1;
				rx_hold <= $urandom_range(20, 200);
			end
		end
	end

	always @(posedge clk) begin : pixel_check
		logic [7:0] want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_pixels.size() == 0) begin
				$error("pixel: no read pending, actual %0h", pixel);
				fail_count++;
			end else begin
				want = pending_pixels.pop_front();
				if (pixel !== want) begin
					$error("pixel: expected %0h actual %0h", want, pixel);
					fail_count++;
				end
			end
		end
	end

	task automatic reset_models();
		for (int unsigned i = 0; i < FB_BYTES; i++)
			fb_model[i] = 8'd0;
		for (int unsigned i = 0; i < STORE_BYTES; i++)
			sprite_model[i] = 8'(i / SPRITE_BYTES);
	endtask

	// applies one accepted request to the model, queues the pixel of a read
	task automatic predict_cmd(input cmd_t c);
		logic [15:0] right;
		int unsigned bottom;
		int unsigned base;
		case (c.kind)
			KIND_FILL: begin
				right = c.x + c.width;
				bottom = int'(c.y) + int'(c.height);
				if (c.x < SCREEN_WIDTH && c.y < SCREEN_HEIGHT &&
						right <= SCREEN_WIDTH && bottom <= SCREEN_HEIGHT) begin
					for (int unsigned r = 32'(c.y); r < bottom; r++)
						for (int unsigned col = 32'(c.x); col < 32'(right); col++)
							fb_model[r * SCREEN_WIDTH + col] = c.color;
				end
			end
			KIND_LOAD: begin
				if (c.sprite_id < SPRITE_COUNT && c.sprite_offset < SPRITE_BYTES)
					sprite_model[c.sprite_id * SPRITE_BYTES + c.sprite_offset] = c.color;
			end
			KIND_DRAW: begin
				if (c.sprite_id < SPRITE_COUNT) begin
					base = c.sprite_id * SPRITE_BYTES;
					// clipping sums are taken without 16-bit wrap
					for (int unsigned i = 0; i < SPRITE_SIZE; i++)
						for (int unsigned j = 0; j < SPRITE_SIZE; j++)
							if (int'(c.x) + j < SCREEN_WIDTH && int'(c.y) + i < SCREEN_HEIGHT)
								fb_model[(c.y + i) * SCREEN_WIDTH + c.x + j] =
									sprite_model[base + i * SPRITE_SIZE + j];
				end
			end
			default: begin
				if (c.x < SCREEN_WIDTH && c.y < SCREEN_HEIGHT)
					pending_pixels.push_back(fb_model[c.y * SCREEN_WIDTH + c.x]);
				else
					pending_pixels.push_back(8'd0);
			end
		endcase
	endtask

	function automatic int unsigned tx_gap_len();
		int unsigned roll;
		if (!tx_gaps_on)
			return 0;
		roll = $urandom_range(0, 99);
		if (roll < 60)
			return 0;
		if (roll < 95)
			return $urandom_range(1, 4);
		return $urandom_range(20, 100);
	endfunction

	// unused fields of each request carry random values
	function automatic cmd_t random_cmd();
		cmd_t c;
		c.kind = cmd_kind_t'($urandom_range(0, 3));
		c.x = 16'($urandom_range(0, 65535));
		c.y = 16'($urandom_range(0, 65535));
		c.width = 16'($urandom_range(0, 65535));
		c.height = 16'($urandom_range(0, 65535));
		c.color = 8'($urandom_range(0, 255));
		c.sprite_id = 8'($urandom_range(0, 255));
		c.sprite_offset = 8'($urandom_range(0, 255));
		return c;
	endfunction

	function automatic cmd_t fill_cmd(input logic [15:0] fx, input logic [15:0] fy,
			input logic [15:0] fw, input logic [15:0] fh, input logic [7:0] fc);
		cmd_t c;
		c = random_cmd();
		c.kind = KIND_FILL;
		c.x = fx;
		c.y = fy;
		c.width = fw;
		c.height = fh;
		c.color = fc;
		return c;
	endfunction

	function automatic cmd_t load_cmd(input logic [7:0] id, input logic [7:0] off,
			input logic [7:0] val);
		cmd_t c;
		c = random_cmd();
		c.kind = KIND_LOAD;
		c.sprite_id = id;
		c.sprite_offset = off;
		c.color = val;
		return c;
	endfunction

	function automatic cmd_t draw_cmd(input logic [7:0] id, input logic [15:0] dx,
			input logic [15:0] dy);
		cmd_t c;
		c = random_cmd();
		c.kind = KIND_DRAW;
		c.sprite_id = id;
		c.x = dx;
		c.y = dy;
		return c;
	endfunction

	function automatic cmd_t read_cmd(input logic [15:0] rx, input logic [15:0] ry);
		cmd_t c;
		c = random_cmd();
		c.kind = KIND_READ;
		c.x = rx;
		c.y = ry;
		return c;
	endfunction

	task automatic issue_cmd(input cmd_t c);
		int unsigned gap;
		kind <= c.kind;
		x <= c.x;
		y <= c.y;
		width <= c.width;
		height <= c.height;
		color <= c.color;
		sprite_id <= c.sprite_id;
		sprite_offset <= c.sprite_offset;
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		predict_cmd(c);
		gap = tx_gap_len();
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// sender holds off until every queued pixel has come back
	task automatic settle_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_pixels.size() != 0)
			@(posedge clk);
	endtask

	task automatic test_power_on_contents();
		issue_cmd(read_cmd(16'd0, 16'd0));
		issue_cmd(draw_cmd(8'd5, 16'd0, 16'd0));
		issue_cmd(read_cmd(16'd15, 16'd15));
		settle_results();
	endtask

	task automatic test_fill_edges();
		issue_cmd(fill_cmd(16'd0, 16'd0, SW16, 16'd1, 8'hff));
		issue_cmd(fill_cmd(SW16 - 16'd1, SH16 - 16'd1, 16'd1, 16'd1, 8'h5a));
		issue_cmd(fill_cmd(16'd5, 16'd0, 16'd1, SH16, 8'h00));
		issue_cmd(fill_cmd(16'd20, 16'd0, 16'd0, 16'd5, 8'h3c));
		issue_cmd(read_cmd(SW16 - 16'd1, 16'd0));
		issue_cmd(read_cmd(SW16 - 16'd1, SH16 - 16'd1));
		issue_cmd(read_cmd(16'd5, SH16 - 16'd1));
		settle_results();
	endtask

	task automatic test_fill_rejects();
		issue_cmd(fill_cmd(SW16, 16'd0, 16'd1, 16'd1, 8'h33));
		issue_cmd(fill_cmd(SW16 - 16'd10, 16'd0, 16'd11, 16'd1, 8'h44));
		issue_cmd(fill_cmd(16'd0, SH16 - 16'd10, 16'd1, 16'd11, 8'h55));
		issue_cmd(fill_cmd(16'd0, 16'hffff, 16'd1, 16'd1, 8'h66));
		// bottom edge must not wrap to pass the height check
		issue_cmd(fill_cmd(16'd0, 16'd100, 16'd1, 16'hffff, 8'h77));
		// right edge wraps below x: accepted but no column written
		issue_cmd(fill_cmd(16'd10, 16'd0, 16'hffff, 16'd1, 8'h88));
		issue_cmd(read_cmd(16'd10, 16'd0));
		settle_results();
	endtask

	task automatic test_sprite_load_draw();
		issue_cmd(load_cmd(8'd255, 8'd0, 8'h00));
		issue_cmd(load_cmd(8'd255, 8'd255, 8'hff));
		issue_cmd(draw_cmd(8'd255, SW16 - 16'd10, SH16 - 16'd10));
		issue_cmd(read_cmd(SW16 - 16'd1, SH16 - 16'd1));
		issue_cmd(read_cmd(SW16 - 16'd10, SH16 - 16'd10));
		settle_results();
	endtask

	task automatic test_clip_and_range();
		issue_cmd(draw_cmd(8'd9, 16'hffff, 16'hffff));
		issue_cmd(read_cmd(16'hffff, 16'hffff));
		issue_cmd(read_cmd(16'd0, SH16));
		settle_results();
	endtask

	function automatic logic [15:0] pick_coord(input int unsigned limit);
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 30)
			return 16'($urandom_range(0, 40));
		if (roll < 60)
			return 16'($urandom_range(limit - 40, limit - 1));
		if (roll < 90)
			return 16'($urandom_range(0, limit - 1));
		return 16'($urandom_range(limit, limit + 60));
	endfunction

	function automatic logic [7:0] pick_sprite();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 50)
			return 8'($urandom_range(0, 7));
		if (roll < 70)
			return 8'($urandom_range(248, 255));
		return 8'($urandom_range(0, 255));
	endfunction

	// mostly small rectangles, a few edge strips and some oversized ones
	function automatic cmd_t scene_fill(input logic [15:0] ax, input logic [15:0] ay);
		logic [15:0] fx, fy, fw, fh;
		int unsigned shape;
		fx = ax + 16'($urandom_range(0, 8));
		fy = ay + 16'($urandom_range(0, 8));
		shape = $urandom_range(0, 99);
		if (shape < 60) begin
			fw = 16'($urandom_range(0, 16));
			fh = 16'($urandom_range(0, 16));
		end else if (shape < 75) begin
			fw = 16'($urandom_range(17, 64));
			fh = 16'($urandom_range(1, 32));
		end else if (shape < 82) begin
			fw = (fx < SCREEN_WIDTH) ? SW16 - fx : 16'd1;
			fh = 16'($urandom_range(1, 4));
		end else if (shape < 89) begin
			fw = 16'($urandom_range(1, 4));
			fh = (fy < SCREEN_HEIGHT) ? SH16 - fy : 16'd1;
		end else if (shape < 95) begin
			fw = 16'($urandom_range(0, 65535));
			fh = 16'($urandom_range(0, 2));
		end else begin
			fw = 16'($urandom_range(0, 16));
			fh = 16'($urandom_range(0, 65535));
		end
		return fill_cmd(fx, fy, fw, fh, 8'($urandom_range(0, 255)));
	endfunction

	// scenes: load a sprite, draw it and fill nearby, then read the area back
	task automatic test_random_scenes();
		int unsigned sent;
		logic [15:0] ax, ay;
		logic [7:0]  id;
		bit          fill_first, do_fill;
		int unsigned roll;
		sent = 0;
		while (sent < SCENE_ITEMS) begin
			if ($urandom_range(0, 99) < 8) begin
				tx_gaps_on = ($urandom_range(0, 3) != 0);
				rx_stall_on = ($urandom_range(0, 3) != 0);
			end
			if ($urandom_range(0, 99) < 12)
				issue_cmd(random_cmd());
			ax = pick_coord(SCREEN_WIDTH);
			ay = pick_coord(SCREEN_HEIGHT);
			id = pick_sprite();
			repeat ($urandom_range(0, 6)) begin
				issue_cmd(load_cmd(id, 8'($urandom_range(0, 255)),
					8'($urandom_range(0, 255))));
				sent++;
			end
			fill_first = ($urandom_range(0, 1) != 0);
			do_fill = ($urandom_range(0, 9) < 7);
			if (do_fill && fill_first) begin
				issue_cmd(scene_fill(ax, ay));
				sent++;
			end
			if ($urandom_range(0, 9) != 0) begin
				issue_cmd(draw_cmd(id, ax, ay));
				sent++;
			end
			if (do_fill && !fill_first) begin
				issue_cmd(scene_fill(ax, ay));
				sent++;
			end
			repeat ($urandom_range(2, 6)) begin
				roll = $urandom_range(0, 99);
				if (roll < 80)
					issue_cmd(read_cmd(ax + 16'($urandom_range(0, 24)),
						ay + 16'($urandom_range(0, 24))));
				else if (roll < 95)
					issue_cmd(read_cmd(16'($urandom_range(0, SCREEN_WIDTH - 1)),
						16'($urandom_range(0, SCREEN_HEIGHT - 1))));
				else
					issue_cmd(read_cmd(16'($urandom_range(0, 65535)),
						16'($urandom_range(0, 65535))));
				sent++;
			end
			if ($urandom_range(0, 99) < 3)
				settle_results();
		end
		settle_results();
	endtask

	initial begin
		reset_models();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		// first requests wait out the clearing pass through in_stall
		tx_gaps_on = 1'b0;
		rx_stall_on = 1'b0;
		test_power_on_contents();
		tx_gaps_on = 1'b1;
		rx_stall_on = 1'b1;
		test_fill_edges();
		test_fill_rejects();
		test_sprite_load_draw();
		test_clip_and_range();
		test_random_scenes();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
